[rtl/rcpr_pkg.sv]
// Package for the RC pulse relay controller: beat types, configuration
// record, register indexes, reset values and mode codes. No dependencies.
package rcpr_pkg;

  localparam int unsigned WidthW  = 15;
  localparam int unsigned MsW     = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RelayW  = 4;
  localparam int unsigned NumLane = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  typedef logic [WidthW-1:0] width_t;
  typedef logic [MsW-1:0]    ms_t;
  typedef logic [TimeW-1:0]  time_t;

  typedef struct packed {
    width_t width_a;
    width_t width_b;
    width_t width_c;
    time_t  now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [RelayW-1:0] relay_bits;
    logic              active;
  } out_beat_t;

  typedef struct packed {
    width_t valid_min;
    width_t valid_max;
    width_t center_width;
    width_t arm_deadband;
    width_t on_threshold;
    width_t off_threshold;
    ms_t    loss_timeout_ms;
    ms_t    mode_holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic in_win;
    logic off_ctr;
    logic above_on;
    logic below_off;
  } lane_flags_t;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegValidMin     = 8'd0;
  localparam cfg_idx_t RegValidMax     = 8'd1;
  localparam cfg_idx_t RegCenterWidth  = 8'd2;
  localparam cfg_idx_t RegArmDeadband  = 8'd3;
  localparam cfg_idx_t RegOnThreshold  = 8'd4;
  localparam cfg_idx_t RegOffThreshold = 8'd5;
  localparam cfg_idx_t RegLossTimeout  = 8'd6;
  localparam cfg_idx_t RegModeHoldoff  = 8'd7;

  localparam cfg_t CfgReset = '{
    valid_min:       15'd900,
    valid_max:       15'd2100,
    center_width:    15'd1500,
    arm_deadband:    15'd100,
    on_threshold:    15'd1700,
    off_threshold:   15'd1300,
    loss_timeout_ms: 16'd500,
    mode_holdoff_ms: 16'd200
  };

  typedef logic [1:0] mode_t;
  localparam mode_t ModeLow  = 2'd0;
  localparam mode_t ModeMid  = 2'd1;
  localparam mode_t ModeHigh = 2'd2;

  localparam int unsigned LaneA = 0;
  localparam int unsigned LaneB = 1;
  localparam int unsigned LaneC = 2;

endpackage

[rtl/rc_pulse_relay_controller.sv]
// Top level of the RC pulse relay controller: config registers, three
// channel lanes and the merging stage. Depends on rcpr_pkg and submodules.
//
// One frame beat in gives one result beat out in the next cycle, and a new
// frame is taken every cycle unless stalled. The three pulse widths are tested
// side by side in one lane each; the merging stage updates arm, relay and mode
// state in the same cycle and loads the output register. Input stalls only while
// the output register holds a beat that the sink is stalling. Config writes are
// always ready and take effect on the next cycle; indexes above 7 are ignored.
module rc_pulse_relay_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rcpr_pkg::in_beat_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rcpr_pkg::out_beat_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  rcpr_pkg::cfg_idx_t           cfg_index_i,
  input  logic [rcpr_pkg::CfgDatW-1:0] cfg_data_i
);
  import rcpr_pkg::*;

  cfg_t        cfg;
  lane_flags_t flags [NumLane];
  width_t      lane_w [NumLane];
  logic        fire;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  assign lane_w[LaneA] = in_data_i.width_a;
  assign lane_w[LaneB] = in_data_i.width_b;
  assign lane_w[LaneC] = in_data_i.width_c;

  rcpr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  for (genvar g = 0; g < NumLane; g++) begin : g_lane
    rcpr_lane u_lane (
      .width_i (lane_w[g]),
      .cfg_i   (cfg),
      .flags_o (flags[g])
    );
  end

  rcpr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .now_i       (in_data_i.now_ms),
    .flags_i     (flags),
    .cfg_i       (cfg),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_relay34_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.relay_bits[3] && out_data_o.relay_bits[2]))
    else $error("relays 3 and 4 both on");

  a_relay_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.relay_bits != 4'd0)) |-> out_data_o.active)
    else $error("relay on while not active");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("accepted frame gave no result beat");
`endif

endmodule

[rtl/rcpr_cfg.sv]
// Configuration register file of the RC pulse relay controller.
// Depends on rcpr_pkg.
module rcpr_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  rcpr_pkg::cfg_idx_t cfg_index_i,
  input  logic [rcpr_pkg::CfgDatW-1:0] cfg_data_i,
  output rcpr_pkg::cfg_t    cfg_o
);
  import rcpr_pkg::*;

  cfg_t   cfg_q, cfg_d;
  width_t v15;
  ms_t    v16;

  assign cfg_ready_o = 1'b1;
  assign v15 = cfg_data_i[WidthW-1:0];
  assign v16 = cfg_data_i[MsW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegValidMin:     cfg_d.valid_min       = v15;
        RegValidMax:     cfg_d.valid_max       = v15;
        RegCenterWidth:  cfg_d.center_width    = v15;
        RegArmDeadband:  cfg_d.arm_deadband    = v15;
        RegOnThreshold:  cfg_d.on_threshold    = v15;
        RegOffThreshold: cfg_d.off_threshold   = v15;
        RegLossTimeout:  cfg_d.loss_timeout_ms = v16;
        RegModeHoldoff:  cfg_d.mode_holdoff_ms = v16;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/rcpr_lane.sv]
// One channel lane: window, deadband and threshold tests on a pulse width.
// Depends on rcpr_pkg.
module rcpr_lane (
  input  rcpr_pkg::width_t      width_i,
  input  rcpr_pkg::cfg_t        cfg_i,
  output rcpr_pkg::lane_flags_t flags_o
);
  import rcpr_pkg::*;

  width_t dev;

  always_comb begin
    if (width_i >= cfg_i.center_width) begin
      dev = width_i - cfg_i.center_width;
    end else begin
      dev = cfg_i.center_width - width_i;
    end
  end

  assign flags_o.in_win    = (width_i > cfg_i.valid_min) && (width_i < cfg_i.valid_max);
  assign flags_o.off_ctr   = dev > cfg_i.arm_deadband;
  assign flags_o.above_on  = width_i > cfg_i.on_threshold;
  assign flags_o.below_off = width_i < cfg_i.off_threshold;

endmodule

[rtl/rcpr_merge.sv]
// Merging stage: combines lane flags with timing state, updates arm, relay
// and mode state and holds the output register. Depends on rcpr_pkg.
module rcpr_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  rcpr_pkg::time_t       now_i,
  input  rcpr_pkg::lane_flags_t flags_i [rcpr_pkg::NumLane],
  input  rcpr_pkg::cfg_t        cfg_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output rcpr_pkg::out_beat_t   out_data_o
);
  import rcpr_pkg::*;

  time_t             lvt_q, lvt_d;
  time_t             lst_q, lst_d;
  logic              armed_q, armed_d;
  logic [RelayW-1:0] relay_q, relay_d;
  mode_t             mode_q, mode_d, mode_sel;
  logic              out_valid_q;
  out_beat_t         out_data_q;
  logic              frame_ok, any_off;
  time_t             since_valid, since_switch;

  always_comb begin
    frame_ok = 1'b1;
    any_off  = 1'b0;
    for (int i = 0; i < NumLane; i++) begin
      frame_ok = frame_ok & flags_i[i].in_win;
      any_off  = any_off | flags_i[i].off_ctr;
    end
  end

  always_comb begin
    lvt_d        = frame_ok ? now_i : lvt_q;
    since_valid  = now_i - lvt_d;
    since_switch = now_i - lst_q;
    armed_d      = armed_q && !(since_valid > {16'd0, cfg_i.loss_timeout_ms});
    if (!armed_d && frame_ok && any_off) begin
      armed_d = 1'b1;
    end

    if (flags_i[LaneC].below_off) begin
      mode_sel = ModeLow;
    end else if (flags_i[LaneC].above_on) begin
      mode_sel = ModeHigh;
    end else begin
      mode_sel = ModeMid;
    end

    relay_d = relay_q;
    lst_d   = lst_q;
    mode_d  = mode_q;
    if (!frame_ok || !armed_d) begin
      relay_d = '0;
    end else begin
      if (flags_i[LaneA].above_on) begin
        relay_d[0] = 1'b1;
      end else if (flags_i[LaneA].below_off) begin
        relay_d[0] = 1'b0;
      end
      if (flags_i[LaneB].above_on) begin
        relay_d[1] = 1'b1;
      end else if (flags_i[LaneB].below_off) begin
        relay_d[1] = 1'b0;
      end
      if ((mode_sel != mode_q) && (since_switch > {16'd0, cfg_i.mode_holdoff_ms})) begin
        lst_d  = now_i;
        mode_d = mode_sel;
        unique case (mode_sel)
          ModeLow:  relay_d[3:2] = 2'b01;
          ModeHigh: relay_d[3:2] = 2'b10;
          default:  relay_d[3:2] = 2'b00;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvt_q       <= '0;
      lst_q       <= '0;
      armed_q     <= 1'b0;
      relay_q     <= '0;
      mode_q      <= ModeMid;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_i) begin
        lvt_q       <= lvt_d;
        lst_q       <= lst_d;
        armed_q     <= armed_d;
        relay_q     <= relay_d;
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      out_data_q.relay_bits <= relay_d;
      out_data_q.active     <= armed_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
